@@ rtl/core/pidsd_pkg.sv @@
// Shared types, widths and command codes for the steering PID block.
// No dependencies; imported by every module of the block.
package pidsd_pkg;

  localparam int COORD_BITS = 12;

  localparam int FW_W    = 13;
  localparam int DB_W    = 11;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 23;
  localparam int DT_W    = 16;
  localparam int ERR_W   = 13;
  localparam int DRIVE_W = 32;

  localparam int ERR_MAX    = 2 ** (ERR_W - 1) - 1;
  localparam int ERR_MIN    = -(2 ** (ERR_W - 1));
  localparam int ERR_WIDE_W = ((COORD_BITS > FW_W - 1) ? COORD_BITS : FW_W - 1) + 2;
  localparam int DIFF_W     = ERR_W + 1;

  localparam int FRAC_SHIFT = 32;
  localparam int QUO_W      = ERR_W + FRAC_SHIFT;
  localparam int DIV_CNT_W  = $clog2(QUO_W);
  localparam int D_W        = QUO_W + 1;

  localparam int MB_W      = 25;
  localparam int MP_W      = GAIN_W + MB_W;
  localparam int INTEG_W   = MB_W;
  localparam int ISUM_W    = 32;
  localparam int ACC_W     = 64;
  localparam int U_W       = 49;
  localparam int SPLIT     = 24;
  localparam int P_SHIFT   = 16;
  localparam int OUT_SHIFT = 12;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_DEADBAND       = 3'd1;
  localparam logic [2:0] REG_GAIN_P         = 3'd2;
  localparam logic [2:0] REG_GAIN_I         = 3'd3;
  localparam logic [2:0] REG_GAIN_D         = 3'd4;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [2:0] REG_OUTPUT_SCALE   = 3'd6;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_E_DT = 3'd1;
  localparam logic [2:0] MUL_P_E  = 3'd2;
  localparam logic [2:0] MUL_I_I  = 3'd3;
  localparam logic [2:0] MUL_D_LO = 3'd4;
  localparam logic [2:0] MUL_D_HI = 3'd5;
  localparam logic [2:0] MUL_U_LO = 3'd6;
  localparam logic [2:0] MUL_U_HI = 3'd7;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_P  = 2'd1;
  localparam logic [1:0] SH_HI = 2'd2;

  typedef struct packed {
    logic [FW_W-1:0]          frame_width;
    logic [DB_W-1:0]          deadband;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]         integral_limit;
    logic signed [GAIN_W-1:0] output_scale;
  } pidsd_cfg_t;

  typedef struct packed {
    logic       in_load;
    logic       err_load;
    logic       div_start;
    logic       int_load;
    logic       d_load;
    logic       u_load;
    logic       out_load;
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic [1:0] acc_sh;
  } pidsd_cmd_t;

endpackage

@@ rtl/core/pid_steering_with_deadband.sv @@
// Steering PID controller with deadband and clamped integral: top level,
// configuration registers and APB port. Uses pidsd_pkg, pidsd_ctrl, pidsd_dp.
//
// One request is worked at a time. A request with a target passes through
// the 45-step restoring divider that forms the derivative before its
// result enters the output register; a request without a target goes
// straight there. The next request can be taken in the cycle after the
// result enters it. The output register lets the next request be taken
// while a result still waits on out_stall. Configuration registers sit at
// byte addresses 0, 4, .. 24 in the order frame width, deadband, P, I and
// D gains, integral limit, output scale.
module pid_steering_with_deadband (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_detected,
  input  logic [pidsd_pkg::COORD_BITS-1:0]     in_target_x,
  input  logic [pidsd_pkg::DT_W-1:0]           in_step_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidsd_pkg::DRIVE_W-1:0] out_drive,
  output logic signed [pidsd_pkg::ERR_W-1:0]   out_position_error,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pidsd_pkg::PADDR_W-1:0]        paddr,
  input  logic [pidsd_pkg::PDATA_W-1:0]        pwdata,
  output logic [pidsd_pkg::PDATA_W-1:0]        prdata,
  output logic                                 pready
);
  import pidsd_pkg::*;

  pidsd_cfg_t cfg_r, cfg_nxt;
  pidsd_cmd_t cmd;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       div_done;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:    cfg_nxt.frame_width    = pwdata[FW_W-1:0];
        REG_DEADBAND:       cfg_nxt.deadband       = pwdata[DB_W-1:0];
        REG_GAIN_P:         cfg_nxt.gain_p         = pwdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_nxt.gain_i         = pwdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_nxt.gain_d         = pwdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = pwdata[LIM_W-1:0];
        REG_OUTPUT_SCALE:   cfg_nxt.output_scale   = pwdata[GAIN_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:    prdata = PDATA_W'(cfg_r.frame_width);
      REG_DEADBAND:       prdata = PDATA_W'(cfg_r.deadband);
      REG_GAIN_P:         prdata = PDATA_W'(cfg_r.gain_p);
      REG_GAIN_I:         prdata = PDATA_W'(cfg_r.gain_i);
      REG_GAIN_D:         prdata = PDATA_W'(cfg_r.gain_d);
      REG_INTEGRAL_LIMIT: prdata = PDATA_W'(cfg_r.integral_limit);
      REG_OUTPUT_SCALE:   prdata = PDATA_W'(cfg_r.output_scale);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= FW_W'(640);
      cfg_r.deadband       <= DB_W'(5);
      cfg_r.gain_p         <= GAIN_W'(819);
      cfg_r.gain_i         <= GAIN_W'(410);
      cfg_r.gain_d         <= GAIN_W'(-41);
      cfg_r.integral_limit <= LIM_W'(6553600);
      cfg_r.output_scale   <= GAIN_W'(-41);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pidsd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_detected (in_detected),
    .out_stall   (out_stall),
    .div_done    (div_done),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  pidsd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .in_detected        (in_detected),
    .in_target_x        (in_target_x),
    .in_step_time       (in_step_time),
    .div_done           (div_done),
    .out_drive          (out_drive),
    .out_position_error (out_position_error)
  );

endmodule

@@ rtl/core/pidsd_div.sv @@
// Restoring divider, one quotient bit per cycle: (mag << 32) / divisor.
// Uses pidsd_pkg widths.
module pidsd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pidsd_pkg::ERR_W-1:0]   dvd_mag,
  input  logic [pidsd_pkg::DT_W-1:0]    dvs,
  output logic                          done,
  output logic [pidsd_pkg::QUO_W-1:0]   quo
);
  import pidsd_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DT_W-1:0]      rem_r, rem_nxt;
  logic [DT_W-1:0]      dvs_r, dvs_nxt;
  logic [QUO_W-1:0]     dq_r, dq_nxt;
  logic [DT_W:0]        trial;
  logic                 qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dq_nxt   = dq_r;
    trial    = {rem_r, dq_r[QUO_W-1]};
    qbit     = trial >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = dvs;
      dq_nxt   = {dvd_mag, {FRAC_SHIFT{1'b0}}};
    end else if (busy_r) begin
      rem_nxt = qbit ? DT_W'(trial - {1'b0, dvs_r}) : trial[DT_W-1:0];
      dq_nxt  = {dq_r[QUO_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dq_r  <= dq_nxt;
  end

  assign done = done_r;
  assign quo  = dq_r;

endmodule

@@ rtl/core/pidsd_dp.sv @@
// Datapath: error and deadband, clamped integral, shared multiplier and
// accumulator, output registers. Uses pidsd_pkg and pidsd_div.
module pidsd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pidsd_pkg::pidsd_cfg_t               cfg,
  input  pidsd_pkg::pidsd_cmd_t               cmd,
  input  logic                                in_detected,
  input  logic [pidsd_pkg::COORD_BITS-1:0]    in_target_x,
  input  logic [pidsd_pkg::DT_W-1:0]          in_step_time,
  output logic                                div_done,
  output logic signed [pidsd_pkg::DRIVE_W-1:0] out_drive,
  output logic signed [pidsd_pkg::ERR_W-1:0]  out_position_error
);
  import pidsd_pkg::*;

  localparam logic signed [ERR_WIDE_W-1:0] EW_MAX = ERR_WIDE_W'(ERR_MAX);
  localparam logic signed [ERR_WIDE_W-1:0] EW_MIN = ERR_WIDE_W'(ERR_MIN);
  localparam logic signed [ACC_W-1:0] U_MAX =
    {{(ACC_W-U_W+1){1'b0}}, 1'b1, {(U_W-2){1'b0}}};
  localparam logic signed [ACC_W-1:0] U_MIN = -U_MAX;
  localparam logic signed [ACC_W-1:0] DRV_MAX =
    {{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DRV_MIN = ~DRV_MAX;

  logic                         det_r, det_nxt;
  logic [COORD_BITS-1:0]        x_r, x_nxt;
  logic [DT_W-1:0]              dt_r, dt_nxt;
  logic signed [ERR_W-1:0]      e_r, e_nxt;
  logic signed [ERR_W-1:0]      last_err_r, last_err_nxt;
  logic signed [INTEG_W-1:0]    integ_r, integ_nxt;
  logic                         neg_r, neg_nxt;
  logic                         dtz_r, dtz_nxt;
  logic signed [D_W-1:0]        d_r, d_nxt;
  logic signed [MP_W-1:0]       prod_r, prod_nxt;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [U_W-1:0]        u_r, u_nxt;
  logic signed [DRIVE_W-1:0]    drive_r, drive_nxt;
  logic signed [ERR_W-1:0]      perr_r, perr_nxt;

  logic signed [ERR_WIDE_W-1:0] xw, spw, ew;
  logic signed [ERR_W-1:0]      esat;
  logic [ERR_W-1:0]             emag;
  logic signed [DIFF_W-1:0]     diff;
  logic [ERR_W-1:0]             dmag;
  logic [QUO_W-1:0]             quo;
  logic signed [D_W-1:0]        dq;
  logic signed [GAIN_W-1:0]     mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [ISUM_W-1:0]     isum, lim, icl;
  logic signed [ACC_W-1:0]      pw, psh, uw, dw;
  logic signed [DRIVE_W-1:0]    drv_sat;

  pidsd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dvd_mag (dmag),
    .dvs     (dt_r),
    .done    (div_done),
    .quo     (quo)
  );

  // error against half frame width, saturated, deadband
  always_comb begin
    xw  = $signed({{(ERR_WIDE_W-COORD_BITS){1'b0}}, x_r});
    spw = $signed({{(ERR_WIDE_W-FW_W+1){1'b0}}, cfg.frame_width[FW_W-1:1]});
    ew  = xw - spw;
    if (ew > EW_MAX) begin
      esat = ERR_W'(ERR_MAX);
    end else if (ew < EW_MIN) begin
      esat = ERR_W'(ERR_MIN);
    end else begin
      esat = ew[ERR_W-1:0];
    end
    emag = esat[ERR_W-1] ? ERR_W'(-esat) : ERR_W'(esat);
  end

  always_comb begin
    diff = DIFF_W'(e_r) - DIFF_W'(last_err_r);
    dmag = diff[DIFF_W-1] ? ERR_W'(-diff) : diff[ERR_W-1:0];
    dq   = $signed({1'b0, quo});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_E_DT: begin
        mul_a = GAIN_W'(e_r);
        mul_b = MB_W'(dt_r);
      end
      MUL_P_E: begin
        mul_a = cfg.gain_p;
        mul_b = MB_W'(e_r);
      end
      MUL_I_I: begin
        mul_a = cfg.gain_i;
        mul_b = integ_r;
      end
      MUL_D_LO: begin
        mul_a = cfg.gain_d;
        mul_b = {1'b0, d_r[SPLIT-1:0]};
      end
      MUL_D_HI: begin
        mul_a = cfg.gain_d;
        mul_b = MB_W'($signed(d_r[D_W-1:SPLIT]));
      end
      MUL_U_LO: begin
        mul_a = cfg.output_scale;
        mul_b = {1'b0, u_r[SPLIT-1:0]};
      end
      MUL_U_HI: begin
        mul_a = cfg.output_scale;
        mul_b = u_r[U_W-1:SPLIT];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    isum = ISUM_W'(integ_r) + $signed(prod_r[ISUM_W-1:0]);
    lim  = $signed({{(ISUM_W-LIM_W){1'b0}}, cfg.integral_limit});
    if (isum > lim) begin
      icl = lim;
    end else if (isum < -lim) begin
      icl = -lim;
    end else begin
      icl = isum;
    end
  end

  always_comb begin
    pw = ACC_W'(prod_r);
    unique case (cmd.acc_sh)
      SH_P:    psh = pw <<< P_SHIFT;
      SH_HI:   psh = pw <<< SPLIT;
      default: psh = pw;
    endcase
    uw = acc_r >>> OUT_SHIFT;
    dw = acc_r >>> OUT_SHIFT;
    if (dw > DRV_MAX) begin
      drv_sat = DRV_MAX[DRIVE_W-1:0];
    end else if (dw < DRV_MIN) begin
      drv_sat = DRV_MIN[DRIVE_W-1:0];
    end else begin
      drv_sat = dw[DRIVE_W-1:0];
    end
  end

  always_comb begin
    det_nxt      = det_r;
    x_nxt        = x_r;
    dt_nxt       = dt_r;
    e_nxt        = e_r;
    last_err_nxt = last_err_r;
    integ_nxt    = integ_r;
    neg_nxt      = neg_r;
    dtz_nxt      = dtz_r;
    d_nxt        = d_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    u_nxt        = u_r;
    drive_nxt    = drive_r;
    perr_nxt     = perr_r;

    if (cmd.in_load) begin
      det_nxt = in_detected;
      x_nxt   = in_target_x;
      dt_nxt  = in_step_time;
    end
    if (cmd.err_load) begin
      e_nxt = (emag < {{(ERR_W-DB_W){1'b0}}, cfg.deadband}) ? '0 : esat;
    end
    if (cmd.div_start) begin
      neg_nxt = diff[DIFF_W-1];
      dtz_nxt = (dt_r == '0);
    end
    if (cmd.int_load) begin
      integ_nxt = icl[INTEG_W-1:0];
    end
    if (cmd.d_load) begin
      if (dtz_r) begin
        d_nxt = '0;
      end else begin
        d_nxt = neg_r ? -dq : dq;
      end
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod_nxt = mul_a * mul_b;
    end
    unique case (cmd.acc_op)
      ACC_LOAD: acc_nxt = psh;
      ACC_ADD:  acc_nxt = acc_r + psh;
      default:  acc_nxt = acc_r;
    endcase
    if (cmd.u_load) begin
      if (uw > U_MAX) begin
        u_nxt = U_MAX[U_W-1:0];
      end else if (uw < U_MIN) begin
        u_nxt = U_MIN[U_W-1:0];
      end else begin
        u_nxt = uw[U_W-1:0];
      end
    end
    if (cmd.out_load) begin
      drive_nxt = det_r ? drv_sat : '0;
      perr_nxt  = det_r ? e_r : '0;
      if (det_r) begin
        last_err_nxt = e_r;
      end else begin
        integ_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r      <= 1'b0;
      last_err_r <= '0;
      integ_r    <= '0;
    end else begin
      det_r      <= det_nxt;
      last_err_r <= last_err_nxt;
      integ_r    <= integ_nxt;
    end
    x_r     <= x_nxt;
    dt_r    <= dt_nxt;
    e_r     <= e_nxt;
    neg_r   <= neg_nxt;
    dtz_r   <= dtz_nxt;
    d_r     <= d_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    u_r     <= u_nxt;
    drive_r <= drive_nxt;
    perr_r  <= perr_nxt;
  end

  assign out_drive          = drive_r;
  assign out_position_error = perr_r;

endmodule

@@ rtl/core/pidsd_ctrl.sv @@
// Sequencer for one request: error, integral, divide wait, gain products,
// output scale and result hand-off. Uses pidsd_pkg command codes.
module pidsd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_detected,
  input  logic                  out_stall,
  input  logic                  div_done,
  output logic                  in_stall,
  output logic                  out_valid,
  output pidsd_pkg::pidsd_cmd_t cmd
);
  import pidsd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ERR   = 4'd1;
  localparam logic [3:0] ST_EDT   = 4'd2;
  localparam logic [3:0] ST_INT   = 4'd3;
  localparam logic [3:0] ST_P     = 4'd4;
  localparam logic [3:0] ST_I     = 4'd5;
  localparam logic [3:0] ST_DWAIT = 4'd6;
  localparam logic [3:0] ST_DLO   = 4'd7;
  localparam logic [3:0] ST_DHI   = 4'd8;
  localparam logic [3:0] ST_DADD  = 4'd9;
  localparam logic [3:0] ST_U     = 4'd10;
  localparam logic [3:0] ST_SLO   = 4'd11;
  localparam logic [3:0] ST_SHI   = 4'd12;
  localparam logic [3:0] ST_SADD  = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_NONE;
    cmd.acc_op  = ACC_HOLD;
    cmd.acc_sh  = SH_0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = in_detected ? ST_ERR : ST_OUT;
        end
      end
      ST_ERR: begin
        cmd.err_load = 1'b1;
        state_nxt    = ST_EDT;
      end
      ST_EDT: begin
        cmd.mul_sel   = MUL_E_DT;
        cmd.div_start = 1'b1;
        state_nxt     = ST_INT;
      end
      ST_INT: begin
        cmd.int_load = 1'b1;
        cmd.mul_sel  = MUL_P_E;
        state_nxt    = ST_P;
      end
      ST_P: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.acc_sh  = SH_P;
        cmd.mul_sel = MUL_I_I;
        state_nxt   = ST_I;
      end
      ST_I: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          cmd.d_load = 1'b1;
          state_nxt  = ST_DLO;
        end
      end
      ST_DLO: begin
        cmd.mul_sel = MUL_D_LO;
        state_nxt   = ST_DHI;
      end
      ST_DHI: begin
        cmd.mul_sel = MUL_D_HI;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_DADD;
      end
      ST_DADD: begin
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = SH_HI;
        state_nxt  = ST_U;
      end
      ST_U: begin
        cmd.u_load = 1'b1;
        state_nxt  = ST_SLO;
      end
      ST_SLO: begin
        cmd.mul_sel = MUL_U_LO;
        state_nxt   = ST_SHI;
      end
      ST_SHI: begin
        cmd.mul_sel = MUL_U_HI;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_SADD;
      end
      ST_SADD: begin
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = SH_HI;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    ovalid_nxt = cmd.out_load | (ovalid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ovalid_r;

endmodule
